// ===== sv/bwsu_pkg.sv =====
// Shared types, codes and constants for the breakpoint/watchpoint stop unit.
// Used by the config, controller, datapath and top-level modules; no dependencies.
package bwsu_pkg;

  // Default size of the trap table in entries.
  localparam int unsigned ADDRESS_SPACE_DEF = 65536;

  // Fixed field widths.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Trap table bit positions.
  localparam int unsigned KIND_EXEC_BIT  = 0;
  localparam int unsigned KIND_READ_BIT  = 1;
  localparam int unsigned KIND_WRITE_BIT = 2;

  // Two-byte break instruction at the program counter.
  localparam logic [15:0] BREAK_PAIR = 16'hEDFF;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RESUME = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_e;

  typedef enum logic [2:0] {
    TRAP_NONE  = 3'd0,
    TRAP_EXEC  = 3'd1,
    TRAP_READ  = 3'd2,
    TRAP_WRITE = 3'd3,
    TRAP_BREAK = 3'd4
  } trap_e;

  typedef enum logic [2:0] {
    MODE_RUN     = 3'd0,
    MODE_SETTLED = 3'd1,
    MODE_TARGET  = 3'd2,
    MODE_RETRACE = 3'd3,
    MODE_GRAIN   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    GRAIN_INSTR = 2'd0,
    GRAIN_LINE  = 2'd1,
    GRAIN_ROW   = 2'd2,
    GRAIN_FRAME = 2'd3
  } grain_e;

  typedef enum logic [2:0] {
    CFG_STOP_MODE   = 3'd0,
    CFG_HONOUR      = 3'd1,
    CFG_TARGET_TICK = 3'd2,
    CFG_STOP_GRAIN  = 3'd3,
    CFG_BREAK_PAIRS = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_SET_RD,
    ST_SET_WR,
    ST_CLR,
    ST_DONE
  } state_e;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0]        stop_mode;
    logic              honour_marks;
    logic [TICK_W-1:0] target_tick;
    logic [1:0]        stop_grain;
    logic              break_pairs;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // load the input word
    logic tick_eval;  // commit a tick and load its result
    logic done_load;  // commit a non-tick action and load its result
    logic walk_rd;    // read the trap entry at the walk address
    logic walk_wr;    // write back the ORed entry and advance the walk
    logic clr_step;   // zero one trap entry and advance the sweep
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;     // output register can take a new word
    logic clr_last;     // sweep stands at the last entry
    logic walk_last;    // walk stands at the last address of the range
    logic range_empty;  // first address of the range exceeds the last
  } sts_t;

endpackage

// ===== sv/breakpoint_watchpoint_stop_unit_core.sv =====
// Top level of the breakpoint/watchpoint stop unit.
// Depends on bwsu_pkg, bwsu_cfg, bwsu_ctrl and bwsu_dp.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    action, beam, address, kinds fields
//   out      output     out_valid_o / out_stall_i  keep_running, stop cause, elapsed ticks
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A tick word first reads the trap table at the access address and at the program
// counter on its two read ports, then evaluates and loads the output word. A set word
// reads each address of its range, then ORs and writes it back; a clear word sweeps the
// whole table to zero; each then loads its result word, as a resume word does.
// After reset the table is swept to zero with in_stall_o high;
// configuration writes are taken throughout. A stalled output word holds the next tick
// in its evaluation cycle until the output register frees up.
module breakpoint_watchpoint_stop_unit_core #(
  parameter int unsigned ADDRESS_SPACE = bwsu_pkg::ADDRESS_SPACE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       in_action_i,
  input  logic                             in_settled_i,
  input  logic [15:0]                      in_program_counter_i,
  input  logic [1:0]                       in_access_kind_i,
  input  logic [15:0]                      in_access_address_i,
  input  logic [15:0]                      in_opcode_pair_i,
  input  logic                             in_frame_ended_i,
  input  logic [15:0]                      in_row_before_i,
  input  logic [15:0]                      in_line_before_i,
  input  logic [15:0]                      in_row_after_i,
  input  logic [15:0]                      in_line_after_i,
  input  logic [2:0]                       in_breakpoint_kinds_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_keep_running_o,
  output logic [2:0]                       out_stop_cause_o,
  output logic [15:0]                      out_stop_addr_o,
  output logic [bwsu_pkg::TICK_W-1:0]      out_elapsed_ticks_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bwsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bwsu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  bwsu_pkg::cfg_t   cfg;
  bwsu_pkg::cmd_t   cmd;
  bwsu_pkg::sts_t   sts;
  bwsu_pkg::state_e ctrl_state;

  // Configuration registers.
  bwsu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  bwsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .state_o     (ctrl_state)
  );

  // Trap table, latch, counter and output register.
  bwsu_dp #(
    .ADDRESS_SPACE (ADDRESS_SPACE)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .cfg_i                 (cfg),
    .in_action_i           (in_action_i),
    .in_settled_i          (in_settled_i),
    .in_program_counter_i  (in_program_counter_i),
    .in_access_kind_i      (in_access_kind_i),
    .in_access_address_i   (in_access_address_i),
    .in_opcode_pair_i      (in_opcode_pair_i),
    .in_frame_ended_i      (in_frame_ended_i),
    .in_row_before_i       (in_row_before_i),
    .in_line_before_i      (in_line_before_i),
    .in_row_after_i        (in_row_after_i),
    .in_line_after_i       (in_line_after_i),
    .in_breakpoint_kinds_i (in_breakpoint_kinds_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_keep_running_o    (out_keep_running_o),
    .out_stop_cause_o      (out_stop_cause_o),
    .out_stop_addr_o       (out_stop_addr_o),
    .out_elapsed_ticks_o   (out_elapsed_ticks_o)
  );

  // Words are only taken when idle or while a tick result leaves.
  a_take_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (ctrl_state == bwsu_pkg::ST_IDLE || ctrl_state == bwsu_pkg::ST_TICK_EVAL))
    else $error("input taken outside idle or tick evaluation");

  // A tick evaluated with a free output register shows its result next cycle.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_state == bwsu_pkg::ST_TICK_EVAL && sts.out_free) |=> out_valid_o)
    else $error("tick result not presented");

  // Each write-back of a range walk follows its own read.
  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_wr |-> $past(cmd.walk_rd))
    else $error("range write-back without a preceding read");

  // A presented stop cause is always a defined code.
  a_trap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_stop_cause_o <= bwsu_pkg::TRAP_BREAK))
    else $error("undefined stop cause presented");

endmodule

// ===== sv/bwsu_cfg.sv =====
// Configuration register file of the stop unit.
// Depends on bwsu_pkg for the register indexes and the cfg_t bundle.
module bwsu_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bwsu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bwsu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output bwsu_pkg::cfg_t                   cfg_o
);

  bwsu_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Decode the register index; indexes past the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bwsu_pkg::CFG_STOP_MODE:   cfg_d.stop_mode    = cfg_data_i[2:0];
        bwsu_pkg::CFG_HONOUR:      cfg_d.honour_marks = cfg_data_i[0];
        bwsu_pkg::CFG_TARGET_TICK: cfg_d.target_tick  = cfg_data_i;
        bwsu_pkg::CFG_STOP_GRAIN:  cfg_d.stop_grain   = cfg_data_i[1:0];
        bwsu_pkg::CFG_BREAK_PAIRS: cfg_d.break_pairs  = cfg_data_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/bwsu_ctrl.sv =====
// Controller state machine of the stop unit: sequences ticks, range walks and sweeps.
// Depends on bwsu_pkg for the state, action, command and status types.
module bwsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_action_i,
  output logic                in_stall_o,
  input  bwsu_pkg::sts_t      sts_i,
  output bwsu_pkg::cmd_t      cmd_o,
  output bwsu_pkg::state_e    state_o
);

  bwsu_pkg::state_e state_q, state_d;
  logic             take;

  // State register; reset starts with a sweep of the trap table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwsu_pkg::ST_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    take    = 1'b0;
    case (state_q)
      bwsu_pkg::ST_INIT_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = bwsu_pkg::ST_IDLE;
      end
      bwsu_pkg::ST_IDLE: begin
        take = 1'b1;
      end
      bwsu_pkg::ST_TICK_RD: begin
        state_d = bwsu_pkg::ST_TICK_EVAL;
      end
      bwsu_pkg::ST_TICK_EVAL: begin
        // The result goes out and the next word can come in on the same edge.
        if (sts_i.out_free) begin
          cmd_o.tick_eval = 1'b1;
          take            = 1'b1;
          state_d         = bwsu_pkg::ST_IDLE;
        end
      end
      bwsu_pkg::ST_SET_RD: begin
        if (sts_i.range_empty) begin
          state_d = bwsu_pkg::ST_DONE;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = bwsu_pkg::ST_SET_WR;
        end
      end
      bwsu_pkg::ST_SET_WR: begin
        cmd_o.walk_wr = 1'b1;
        state_d = sts_i.walk_last ? bwsu_pkg::ST_DONE : bwsu_pkg::ST_SET_RD;
      end
      bwsu_pkg::ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = bwsu_pkg::ST_DONE;
      end
      bwsu_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_load = 1'b1;
          state_d         = bwsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bwsu_pkg::ST_IDLE;
      end
    endcase

    // Accept a new word and branch on its action.
    if (take && in_valid_i) begin
      cmd_o.capture = 1'b1;
      case (in_action_i)
        bwsu_pkg::ACT_TICK:   state_d = bwsu_pkg::ST_TICK_RD;
        bwsu_pkg::ACT_SET:    state_d = bwsu_pkg::ST_SET_RD;
        bwsu_pkg::ACT_CLEAR:  state_d = bwsu_pkg::ST_CLR;
        bwsu_pkg::ACT_RESUME: state_d = bwsu_pkg::ST_DONE;
        default:              state_d = bwsu_pkg::ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = !take;
  assign state_o    = state_q;

endmodule

// ===== sv/bwsu_dp.sv =====
// Datapath of the stop unit: input word, trap table memory, trap latch, tick counter
// and output register. Depends on bwsu_pkg; driven by commands from bwsu_ctrl.
module bwsu_dp #(
  parameter int unsigned ADDRESS_SPACE = bwsu_pkg::ADDRESS_SPACE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bwsu_pkg::cmd_t                cmd_i,
  output bwsu_pkg::sts_t                sts_o,
  input  bwsu_pkg::cfg_t                cfg_i,
  input  logic [1:0]                    in_action_i,
  input  logic                          in_settled_i,
  input  logic [15:0]                   in_program_counter_i,
  input  logic [1:0]                    in_access_kind_i,
  input  logic [15:0]                   in_access_address_i,
  input  logic [15:0]                   in_opcode_pair_i,
  input  logic                          in_frame_ended_i,
  input  logic [15:0]                   in_row_before_i,
  input  logic [15:0]                   in_line_before_i,
  input  logic [15:0]                   in_row_after_i,
  input  logic [15:0]                   in_line_after_i,
  input  logic [2:0]                    in_breakpoint_kinds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_keep_running_o,
  output logic [2:0]                    out_stop_cause_o,
  output logic [15:0]                   out_stop_addr_o,
  output logic [bwsu_pkg::TICK_W-1:0]   out_elapsed_ticks_o
);

  localparam int unsigned AW         = $clog2(ADDRESS_SPACE);
  localparam int unsigned SLOT_STEPS = 17 - AW;
  localparam logic [16:0] SPACE_W    = 17'(ADDRESS_SPACE);
  localparam logic [AW-1:0] LAST_SLOT = AW'(ADDRESS_SPACE - 1);

  // Address modulo the table size, by a short chain of compare and subtract steps.
  function automatic logic [AW-1:0] slot(input logic [15:0] addr);
    logic [16:0] rem;
    rem = {1'b0, addr};
    for (int i = SLOT_STEPS - 1; i >= 0; i--) begin
      if (rem >= (SPACE_W << i)) rem = rem - (SPACE_W << i);
    end
    return rem[AW-1:0];
  endfunction

  // Captured input word.
  logic [1:0]  act_q;
  logic        settled_q;
  logic [15:0] pc_q;
  logic [1:0]  acc_q;
  logic [15:0] addr_q;
  logic [15:0] pair_q;
  logic        frame_q;
  logic [15:0] rowb_q, lineb_q, rowa_q, linea_q;
  logic [2:0]  kinds_q;
  logic [15:0] walk_q;

  // Trap table and its ports.
  logic [2:0]    trap_mem [ADDRESS_SPACE];
  logic [2:0]    rd_a_q, rd_b_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra, mem_rb;
  logic [2:0]    mem_wd;
  logic [AW-1:0] clr_q;
  logic          clr_last;

  // Architectural state.
  logic [2:0]                  kinds_use_q;
  bwsu_pkg::trap_e             lk_q;
  logic [15:0]                 la_q;
  logic [bwsu_pkg::TICK_W-1:0] tick_q;

  // Output register.
  logic                        out_valid_q;
  logic                        keep_q;
  logic [2:0]                  kind_q;
  logic [15:0]                 taddr_q;
  logic [bwsu_pkg::TICK_W-1:0] elapsed_q;

  // Tick evaluation.
  logic [bwsu_pkg::TICK_W-1:0] tick_inc;
  bwsu_pkg::trap_e             lk_watch, lk_eval;
  logic [15:0]                 la_watch, la_eval;
  logic                        mark_stop, mode_stop, grain_hit, keep_eval;

  // Capture the input word and advance the range walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= in_action_i;
      settled_q <= in_settled_i;
      pc_q      <= in_program_counter_i;
      acc_q     <= in_access_kind_i;
      addr_q    <= in_access_address_i;
      pair_q    <= in_opcode_pair_i;
      frame_q   <= in_frame_ended_i;
      rowb_q    <= in_row_before_i;
      lineb_q   <= in_line_before_i;
      rowa_q    <= in_row_after_i;
      linea_q   <= in_line_after_i;
      kinds_q   <= in_breakpoint_kinds_i;
      walk_q    <= in_access_address_i;
    end else if (cmd_i.walk_wr) begin
      walk_q <= walk_q + 16'd1;
    end
  end

  // Memory port selection: sweep or walk on the write side, two reads per cycle.
  assign mem_we = cmd_i.clr_step || cmd_i.walk_wr;
  assign mem_wa = cmd_i.clr_step ? clr_q : slot(walk_q);
  assign mem_wd = cmd_i.clr_step ? 3'b000 : (rd_a_q | kinds_q);
  assign mem_ra = cmd_i.walk_rd ? slot(walk_q) : slot(addr_q);
  assign mem_rb = slot(pc_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) trap_mem[mem_wa] <= mem_wd;
    rd_a_q <= trap_mem[mem_ra];
    rd_b_q <= trap_mem[mem_rb];
  end

  // Sweep counter wraps back to zero after the last entry.
  assign clr_last = (clr_q == LAST_SLOT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_last ? '0 : clr_q + AW'(1);
    end
  end

  // Watch hit, marks and stop mode for a tick.
  always_comb begin
    tick_inc = tick_q + 64'd1;

    lk_watch = lk_q;
    la_watch = la_q;
    if ((kinds_use_q[bwsu_pkg::KIND_READ_BIT] || kinds_use_q[bwsu_pkg::KIND_WRITE_BIT]) &&
        lk_q == bwsu_pkg::TRAP_NONE) begin
      if (acc_q == bwsu_pkg::ACC_READ && rd_a_q[bwsu_pkg::KIND_READ_BIT]) begin
        lk_watch = bwsu_pkg::TRAP_READ;
        la_watch = addr_q;
      end else if (acc_q == bwsu_pkg::ACC_WRITE && rd_a_q[bwsu_pkg::KIND_WRITE_BIT]) begin
        lk_watch = bwsu_pkg::TRAP_WRITE;
        la_watch = addr_q;
      end
    end

    lk_eval   = lk_watch;
    la_eval   = la_watch;
    mark_stop = 1'b0;
    if (cfg_i.honour_marks) begin
      if (lk_watch != bwsu_pkg::TRAP_NONE) begin
        mark_stop = settled_q;
      end else if ((kinds_use_q[bwsu_pkg::KIND_EXEC_BIT] || cfg_i.break_pairs) &&
                   settled_q) begin
        if (rd_b_q[bwsu_pkg::KIND_EXEC_BIT]) begin
          lk_eval   = bwsu_pkg::TRAP_EXEC;
          la_eval   = pc_q;
          mark_stop = 1'b1;
        end else if (cfg_i.break_pairs && pair_q == bwsu_pkg::BREAK_PAIR) begin
          lk_eval   = bwsu_pkg::TRAP_BREAK;
          la_eval   = pc_q;
          mark_stop = 1'b1;
        end
      end
    end

    case (cfg_i.stop_grain)
      bwsu_pkg::GRAIN_INSTR: grain_hit = 1'b1;
      bwsu_pkg::GRAIN_LINE:  grain_hit = (rowa_q != rowb_q) || (linea_q != lineb_q);
      bwsu_pkg::GRAIN_ROW:   grain_hit = (rowa_q != rowb_q);
      default:               grain_hit = frame_q;
    endcase

    case (cfg_i.stop_mode)
      bwsu_pkg::MODE_SETTLED: mode_stop = settled_q;
      bwsu_pkg::MODE_TARGET:  mode_stop = (tick_inc >= cfg_i.target_tick);
      bwsu_pkg::MODE_RETRACE: mode_stop = (lk_eval == bwsu_pkg::TRAP_NONE) && frame_q;
      bwsu_pkg::MODE_GRAIN:   mode_stop = grain_hit;
      default:                mode_stop = 1'b0;
    endcase

    keep_eval = !(mark_stop || mode_stop);
  end

  // Architectural state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_use_q <= '0;
      lk_q        <= bwsu_pkg::TRAP_NONE;
      la_q        <= '0;
      tick_q      <= '0;
    end else if (cmd_i.tick_eval) begin
      tick_q <= tick_inc;
      lk_q   <= lk_eval;
      la_q   <= la_eval;
    end else if (cmd_i.done_load) begin
      case (act_q)
        bwsu_pkg::ACT_SET:    kinds_use_q <= kinds_use_q | kinds_q;
        bwsu_pkg::ACT_CLEAR:  kinds_use_q <= '0;
        bwsu_pkg::ACT_RESUME: lk_q <= bwsu_pkg::TRAP_NONE;
        default:              lk_q <= lk_q;
      endcase
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick_eval || cmd_i.done_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_eval) begin
      keep_q    <= keep_eval;
      kind_q    <= lk_eval;
      taddr_q   <= la_eval;
      elapsed_q <= tick_inc;
    end else if (cmd_i.done_load) begin
      keep_q    <= 1'b1;
      kind_q    <= (act_q == bwsu_pkg::ACT_RESUME) ? bwsu_pkg::TRAP_NONE : lk_q;
      taddr_q   <= la_q;
      elapsed_q <= tick_q;
    end
  end

  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.clr_last    = clr_last;
  assign sts_o.walk_last   = (walk_q == pc_q);
  assign sts_o.range_empty = (addr_q > pc_q);

  assign out_valid_o         = out_valid_q;
  assign out_keep_running_o  = keep_q;
  assign out_stop_cause_o    = kind_q;
  assign out_stop_addr_o     = taddr_q;
  assign out_elapsed_ticks_o = elapsed_q;

endmodule

// ===== sim/breakpoint_watchpoint_stop_unit_core_tb.sv =====
// Self-checking testbench for breakpoint_watchpoint_stop_unit_core.
// Predicts each result word from its own model of the trap table and stop logic.
// Depends on bwsu_pkg and the core RTL only.
`timescale 1ns / 1ps

module breakpoint_watchpoint_stop_unit_core_tb;
  import bwsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int          PHASES          = 16;
  localparam int          WORDS_PER_PHASE = 96;
  localparam int          HOLD_AT_WORD    = 600;
  localparam int          HOLD_CYCLES     = 400;
  localparam logic [15:0] HOT_BASE        = 16'h4000;
  localparam logic [1:0]  ACC_SPARE       = 2'd3;
  localparam logic [2:0]  CFG_SPARE_IDX   = 3'd7;
  localparam logic [2:0]  MODE_SPARE_5    = 3'd5;
  localparam logic [2:0]  MODE_SPARE_6    = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7    = 3'd7;

  typedef struct {
    act_e        action;
    bit          settled;
    bit [15:0]   pc;
    logic [1:0]  access;
    bit [15:0]   addr;
    bit [15:0]   pair;
    bit          frame;
    bit [15:0]   row_before;
    bit [15:0]   line_before;
    bit [15:0]   row_after;
    bit [15:0]   line_after;
    bit [2:0]    kinds;
  } tick_word_t;

  typedef struct {
    bit              keep;
    trap_e           kind;
    bit [15:0]       addr;
    bit [TICK_W-1:0] ticks;
  } stop_verdict_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Block ports; every input is known from time zero.
  logic                  in_valid_i            = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            in_action_i           = '0;
  logic                  in_settled_i          = 1'b0;
  logic [15:0]           in_program_counter_i  = '0;
  logic [1:0]            in_access_kind_i      = '0;
  logic [15:0]           in_access_address_i   = '0;
  logic [15:0]           in_opcode_pair_i      = '0;
  logic                  in_frame_ended_i      = 1'b0;
  logic [15:0]           in_row_before_i       = '0;
  logic [15:0]           in_line_before_i      = '0;
  logic [15:0]           in_row_after_i        = '0;
  logic [15:0]           in_line_after_i       = '0;
  logic [2:0]            in_breakpoint_kinds_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i           = 1'b0;
  logic                  out_keep_running_o;
  logic [2:0]            out_stop_cause_o;
  logic [15:0]           out_stop_addr_o;
  logic [TICK_W-1:0]     out_elapsed_ticks_o;
  logic                  cfg_valid_i           = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i           = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i            = '0;

  breakpoint_watchpoint_stop_unit_core #(
    .ADDRESS_SPACE(ADDRESS_SPACE_DEF)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_action_i           (in_action_i),
    .in_settled_i          (in_settled_i),
    .in_program_counter_i  (in_program_counter_i),
    .in_access_kind_i      (in_access_kind_i),
    .in_access_address_i   (in_access_address_i),
    .in_opcode_pair_i      (in_opcode_pair_i),
    .in_frame_ended_i      (in_frame_ended_i),
    .in_row_before_i       (in_row_before_i),
    .in_line_before_i      (in_line_before_i),
    .in_row_after_i        (in_row_after_i),
    .in_line_after_i       (in_line_after_i),
    .in_breakpoint_kinds_i (in_breakpoint_kinds_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_keep_running_o    (out_keep_running_o),
    .out_stop_cause_o      (out_stop_cause_o),
    .out_stop_addr_o       (out_stop_addr_o),
    .out_elapsed_ticks_o   (out_elapsed_ticks_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  // Predicted block state and configuration.
  bit [2:0]        trap_mem [0:ADDRESS_SPACE_DEF-1];
  bit [2:0]        kinds_used;
  trap_e           latch_kind = TRAP_NONE;
  bit [15:0]       latch_addr;
  bit [TICK_W-1:0] tick_total;
  logic [2:0]      cfg_mode;
  bit              cfg_honour;
  bit [TICK_W-1:0] cfg_target;
  logic [1:0]      cfg_grain;
  bit              cfg_pairs;

  // Testbench bookkeeping.
  tick_word_t    word_q[$];
  stop_verdict_t verdict_q[$];
  tick_word_t    shown;
  int unsigned   send_gap      = 0;
  int unsigned   recv_gap      = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   words_taken   = 0;
  int unsigned   hold_left     = 0;
  bit            hold_done     = 1'b0;
  int unsigned   mismatches    = 0;
  int unsigned   cycle_count   = 0;

  // Mirror a register write into the predicted configuration.
  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      CFG_STOP_MODE:   cfg_mode   = val[2:0];
      CFG_HONOUR:      cfg_honour = val[0];
      CFG_TARGET_TICK: cfg_target = val;
      CFG_STOP_GRAIN:  cfg_grain  = val[1:0];
      CFG_BREAK_PAIRS: cfg_pairs  = val[0];
      default: ;
    endcase
  endfunction

  // Work out the result word of one accepted word and advance the state.
  function automatic stop_verdict_t predict_verdict(tick_word_t w);
    stop_verdict_t v;
    bit            halt;
    bit            crossed;
    int unsigned   a;
    v.keep = 1'b1;
    case (w.action)
      ACT_SET: begin
        for (a = w.addr; a <= w.pc; a++) trap_mem[a] = trap_mem[a] | w.kinds;
        kinds_used = kinds_used | w.kinds;
      end
      ACT_CLEAR: begin
        foreach (trap_mem[i]) trap_mem[i] = '0;
        kinds_used = '0;
      end
      ACT_RESUME: latch_kind = TRAP_NONE;
      default: begin
        halt = 1'b0;
        tick_total++;
        // The first read or write watch hit is latched.
        if ((kinds_used[KIND_READ_BIT] || kinds_used[KIND_WRITE_BIT]) &&
            latch_kind == TRAP_NONE) begin
          if (w.access == ACC_READ && trap_mem[w.addr][KIND_READ_BIT]) begin
            latch_kind = TRAP_READ;
            latch_addr = w.addr;
          end else if (w.access == ACC_WRITE && trap_mem[w.addr][KIND_WRITE_BIT]) begin
            latch_kind = TRAP_WRITE;
            latch_addr = w.addr;
          end
        end
        // Breakpoints and break pairs only fire at a settled program counter.
        if (cfg_honour) begin
          if (latch_kind != TRAP_NONE) begin
            halt = w.settled;
          end else if (w.settled && (kinds_used[KIND_EXEC_BIT] || cfg_pairs)) begin
            if (trap_mem[w.pc][KIND_EXEC_BIT]) begin
              latch_kind = TRAP_EXEC;
              latch_addr = w.pc;
              halt = 1'b1;
            end else if (cfg_pairs && w.pair == BREAK_PAIR) begin
              latch_kind = TRAP_BREAK;
              latch_addr = w.pc;
              halt = 1'b1;
            end
          end
        end
        case (cfg_grain)
          GRAIN_INSTR: crossed = 1'b1;
          GRAIN_LINE:  crossed = w.row_after != w.row_before || w.line_after != w.line_before;
          GRAIN_ROW:   crossed = w.row_after != w.row_before;
          default:     crossed = w.frame;
        endcase
        case (cfg_mode)
          MODE_SETTLED: halt = halt || w.settled;
          MODE_TARGET:  halt = halt || tick_total >= cfg_target;
          MODE_RETRACE: halt = halt || (latch_kind == TRAP_NONE && w.frame);
          MODE_GRAIN:   halt = halt || crossed;
          default: ;
        endcase
        v.keep = !halt;
      end
    endcase
    v.kind  = latch_kind;
    v.addr  = latch_addr;
    v.ticks = tick_total;
    return v;
  endfunction

  // Addresses mostly fall in a small hot window so that traps get hit.
  function automatic bit [15:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return HOT_BASE + 16'($urandom_range(0, 63));
    return 16'($urandom_range(0, 65535));
  endfunction

  // One random word; every field is filled whatever the action.
  function automatic tick_word_t draw_word();
    tick_word_t  w;
    int unsigned r;
    int unsigned first;
    int unsigned last;
    w.settled     = 1'($urandom_range(0, 1));
    w.pc          = pick_addr();
    w.access      = 2'($urandom_range(0, 3));
    w.addr        = pick_addr();
    w.frame       = $urandom_range(0, 4) == 0;
    w.row_before  = 16'($urandom_range(0, 65535));
    w.line_before = 16'($urandom_range(0, 65535));
    w.row_after   = w.row_before;
    w.line_after  = w.line_before;
    w.kinds       = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 20) w.pair = BREAK_PAIR;
    else if (r < 25) w.pair = {BREAK_PAIR[15:8], 8'($urandom_range(0, 255))};
    else if (r < 30) w.pair = {8'($urandom_range(0, 255)), BREAK_PAIR[7:0]};
    else w.pair = 16'($urandom_range(0, 65535));
    // Beam moves: none, within a row, or to another row.
    r = $urandom_range(0, 3);
    if (r == 2) w.line_after = 16'($urandom_range(0, 65535));
    if (r == 3) w.row_after = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // Range set: mostly short, now and then long or empty.
      w.action = ACT_SET;
      first = ($urandom_range(0, 9) < 8) ? HOT_BASE + $urandom_range(0, 63)
                                         : $urandom_range(1, 65535);
      r = $urandom_range(0, 99);
      if (r < 8) last = first - 1 - $urandom_range(0, (first > 40) ? 40 : first - 1);
      else if (r < 18) last = first + $urandom_range(16, 300);
      else last = first + $urandom_range(0, 15);
      if (last > 65535) last = 65535;
      w.addr = 16'(first);
      w.pc   = 16'(last);
    end else if (r < 14) begin
      w.action = ACT_RESUME;
    end else begin
      w.action = ACT_TICK;
    end
    return w;
  endfunction

  // Directed word; the beam fields and frame flag come from a random draw.
  task automatic push_dir(act_e act, bit settled, bit [15:0] pc, logic [1:0] acc,
                          bit [15:0] addr, bit [15:0] pair, bit [2:0] kinds);
    tick_word_t w;
    w = draw_word();
    w.action  = act;
    w.settled = settled;
    w.pc      = pc;
    w.access  = acc;
    w.addr    = addr;
    w.pair    = pair;
    w.kinds   = kinds;
    word_q.push_back(w);
  endtask

  // Register write over the configuration channel.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued word is through and every result has come back.
  task automatic drain();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [2:0] mode_for_phase(int p);
    case (p)
      0:  return MODE_RUN;
      1:  return MODE_TARGET;
      2:  return MODE_SETTLED;
      3:  return MODE_RETRACE;
      4, 5, 6, 7: return MODE_GRAIN;
      8:  return MODE_SPARE_5;
      9:  return MODE_SPARE_6;
      10: return MODE_SPARE_7;
      11: return MODE_TARGET;
      12: return MODE_RETRACE;
      13: return MODE_SETTLED;
      14: return MODE_TARGET;
      default: return MODE_GRAIN;
    endcase
  endfunction

  // Input driver: presents queued words and predicts each one taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(predict_verdict(shown));
        words_taken <= words_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(1, 100) <= send_idle_pct) begin
          send_gap = $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          shown = word_q.pop_front();
          in_valid_i            <= 1'b1;
          in_action_i           <= shown.action;
          in_settled_i          <= shown.settled;
          in_program_counter_i  <= shown.pc;
          in_access_kind_i      <= shown.access;
          in_access_address_i   <= shown.addr;
          in_opcode_pair_i      <= shown.pair;
          in_frame_ended_i      <= shown.frame;
          in_row_before_i       <= shown.row_before;
          in_line_before_i      <= shown.line_before;
          in_row_after_i        <= shown.row_after;
          in_line_after_i       <= shown.line_after;
          in_breakpoint_kinds_i <= shown.kinds;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off once the run is well under way.
  always @(posedge clk_i) begin
    if (!hold_done && words_taken >= HOLD_AT_WORD) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: checks each result word and throttles the output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, keep %0d cause %0d at %h ticks %0d",
                   $time, out_keep_running_o, out_stop_cause_o, out_stop_addr_o,
                   out_elapsed_ticks_o);
        end else begin
          if (out_keep_running_o !== verdict_q[0].keep) begin
            mismatches++;
            $display("%0t: keep_running expected %0d, got %0d", $time,
                     verdict_q[0].keep, out_keep_running_o);
          end
          if (out_stop_cause_o !== verdict_q[0].kind) begin
            mismatches++;
            $display("%0t: stop cause expected %0d, got %0d", $time,
                     verdict_q[0].kind, out_stop_cause_o);
          end
          if (out_stop_addr_o !== verdict_q[0].addr) begin
            mismatches++;
            $display("%0t: stop address expected %h, got %h", $time,
                     verdict_q[0].addr, out_stop_addr_o);
          end
          if (out_elapsed_ticks_o !== verdict_q[0].ticks) begin
            mismatches++;
            $display("%0t: elapsed_ticks expected %0d, got %0d", $time,
                     verdict_q[0].ticks, out_elapsed_ticks_o);
          end
          void'(verdict_q.pop_front());
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
        recv_gap = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    tick_word_t w;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: marks honored, break pairs on, stop when settled.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    write_reg(CFG_STOP_MODE, 64'(MODE_SETTLED));
    write_reg(CFG_HONOUR, 64'd1);
    write_reg(CFG_TARGET_TICK, 64'd0);
    write_reg(CFG_STOP_GRAIN, 64'(GRAIN_INSTR));
    write_reg(CFG_BREAK_PAIRS, 64'd1);
    push_dir(ACT_TICK, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b1, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_SET, 1'b0, 16'h1003, ACC_NONE, 16'h1000, 16'h0000, 3'b011);
    // Empty range still adds its kinds to the kinds in use.
    push_dir(ACT_SET, 1'b0, 16'h2000, ACC_NONE, 16'h2001, 16'h0000, 3'b100);
    push_dir(ACT_SET, 1'b0, 16'h2000, ACC_NONE, 16'h2000, 16'h0000, 3'b100);
    push_dir(ACT_TICK, 1'b0, 16'h0000, ACC_READ, 16'h1002, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b1, 16'h1000, ACC_WRITE, 16'h2000, 16'h0000, 3'd0);
    push_dir(ACT_RESUME, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b0, 16'h0000, ACC_WRITE, 16'h2000, 16'h0000, 3'd0);
    push_dir(ACT_RESUME, 1'b1, 16'hFFFF, ACC_SPARE, 16'hFFFF, 16'hFFFF, 3'd7);
    push_dir(ACT_TICK, 1'b1, 16'h1001, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_RESUME, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b1, 16'h3000, ACC_NONE, 16'h0000, BREAK_PAIR, 3'd0);
    // Clearing the table leaves the latched trap standing.
    push_dir(ACT_CLEAR, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b1, 16'hFFFF, ACC_SPARE, 16'h1002, 16'hFFFF, 3'd0);
    push_dir(ACT_RESUME, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_SET, 1'b0, 16'hFFFF, ACC_NONE, 16'h0000, 16'h0000, 3'b111);
    push_dir(ACT_TICK, 1'b1, 16'hFFFF, ACC_WRITE, 16'hFFFF, 16'h0000, 3'd0);
    push_dir(ACT_RESUME, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_TICK, 1'b0, 16'h0000, ACC_READ, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_RESUME, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    push_dir(ACT_CLEAR, 1'b0, 16'h0000, ACC_NONE, 16'h0000, 16'h0000, 3'd0);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 35);
        recv_idle_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 35);
      end
      write_reg(CFG_STOP_MODE, 64'(mode_for_phase(p)));
      write_reg(CFG_HONOUR, 64'(p % 3 != 0));
      case (p % 4)
        1: write_reg(CFG_TARGET_TICK, 64'd0);
        3: write_reg(CFG_TARGET_TICK, '1);
        default: write_reg(CFG_TARGET_TICK, tick_total + $urandom_range(0, 120));
      endcase
      write_reg(CFG_STOP_GRAIN, 64'(p % 4));
      write_reg(CFG_BREAK_PAIRS, 64'(p % 5 != 1));
      // An unused register index must change nothing.
      if (p == 3) write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
      if (p == 5 || p == 11) begin
        w = draw_word();
        w.action = ACT_CLEAR;
        word_q.push_back(w);
      end
      repeat (WORDS_PER_PHASE) word_q.push_back(draw_word());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bwsu_pkg.sv
sv/bwsu_cfg.sv
sv/bwsu_ctrl.sv
sv/bwsu_dp.sv
sv/breakpoint_watchpoint_stop_unit_core.sv
sim/breakpoint_watchpoint_stop_unit_core_tb.sv
